[rtl/glyph_quad_vertex_generator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Glyph quad vertex generator assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define GLYPH_QUAD_VERTEX_GENERATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define GQVG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gqvg: property violated");
// The expression must never be true outside reset.
`define GQVG_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("gqvg: forbidden condition seen");
`else
`define GQVG_ASSERT(lbl, prop)
`define GQVG_NEVER(lbl, expr)
`endif

`endif

[rtl/gqvg_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph quad vertex generator package
// Glyph table entry layout, register indexes and the sequencer microcode.
// ----------------------------------------------------------------------------
`default_nettype none

package gqvg_pkg;

  // Configuration register indexes.
  localparam logic [3:0] REG_ATLAS_W = 4'd0;
  localparam logic [3:0] REG_ATLAS_H = 4'd1;

  localparam logic [12:0] ATLAS_RESET = 13'd256;
  localparam logic [15:0] TEX_MAX     = 16'hFFFF;
  // Sixteen quotient bits, counted down to zero.
  localparam logic [3:0]  DIV_LAST    = 4'd15;

  // One glyph table entry; the bearings are two's complement.
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic [11:0] bx;
    logic [11:0] by;
    logic [11:0] adv;
  } glyph_t;

  // Program steps of the sequencer.
  typedef enum logic [3:0] {
    PC_WAIT,
    PC_DISPATCH,
    PC_STORE,
    PC_SETUP,
    PC_DIV,
    PC_EMIT0,
    PC_EMIT1,
    PC_EMIT2,
    PC_EMIT3,
    PC_EMIT4,
    PC_EMIT5,
    PC_MISS
  } pc_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_STORE,
    ACT_SETUP,
    ACT_DIV,
    ACT_EMIT,
    ACT_MISS
  } act_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_ACC,
    COND_DRAW,
    COND_MISS,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  // One control word: action, jump condition, jump and fall-through targets,
  // and the quad corner that an emit step sends out.
  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_e   jmp;
    pc_e   nxt;
    logic  right;
    logic  top;
    logic  last;
  } ctrl_t;

  function automatic ctrl_t ucode(pc_e pc);
    ctrl_t w;
    case (pc)
      PC_WAIT:     w = '{ACT_ACCEPT, COND_NO_ACC,   PC_WAIT,  PC_DISPATCH, 1'b0, 1'b0, 1'b0};
      PC_DISPATCH: w = '{ACT_NONE,   COND_DRAW,     PC_SETUP, PC_STORE,    1'b0, 1'b0, 1'b0};
      PC_STORE:    w = '{ACT_STORE,  COND_ALWAYS,   PC_WAIT,  PC_WAIT,     1'b0, 1'b0, 1'b0};
      PC_SETUP:    w = '{ACT_SETUP,  COND_MISS,     PC_MISS,  PC_DIV,      1'b0, 1'b0, 1'b0};
      PC_DIV:      w = '{ACT_DIV,    COND_DIV_MORE, PC_DIV,   PC_EMIT0,    1'b0, 1'b0, 1'b0};
      PC_EMIT0:    w = '{ACT_EMIT,   COND_OUT_BUSY, PC_EMIT0, PC_EMIT1,    1'b0, 1'b0, 1'b0};
      PC_EMIT1:    w = '{ACT_EMIT,   COND_OUT_BUSY, PC_EMIT1, PC_EMIT2,    1'b1, 1'b1, 1'b0};
      PC_EMIT2:    w = '{ACT_EMIT,   COND_OUT_BUSY, PC_EMIT2, PC_EMIT3,    1'b0, 1'b1, 1'b0};
      PC_EMIT3:    w = '{ACT_EMIT,   COND_OUT_BUSY, PC_EMIT3, PC_EMIT4,    1'b0, 1'b0, 1'b0};
      PC_EMIT4:    w = '{ACT_EMIT,   COND_OUT_BUSY, PC_EMIT4, PC_EMIT5,    1'b1, 1'b0, 1'b0};
      PC_EMIT5:    w = '{ACT_EMIT,   COND_OUT_BUSY, PC_EMIT5, PC_WAIT,     1'b1, 1'b1, 1'b1};
      PC_MISS:     w = '{ACT_MISS,   COND_OUT_BUSY, PC_MISS,  PC_WAIT,     1'b0, 1'b0, 1'b1};
      default:     w = '{ACT_NONE,   COND_ALWAYS,   PC_WAIT,  PC_WAIT,     1'b0, 1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/gqvg_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gqvg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/glyph_quad_vertex_generator_unit.sv]
// ----------------------------------------------------------------------------
// Glyph quad vertex generator
// Turns character codes into six textured vertices per loaded glyph, or one
// missing-glyph result, for a bitmap font, driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------------
//   in       input      in_valid_i / in_ready_o   mode, char_code, start_of_text,
//                                                 glyph rectangle and metrics
//   out      output     out_valid_o / out_ready_i pos_x, pos_y, tex_u, tex_v,
//                                                 missing_glyph, last
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A load transfer passes through the dispatch and store steps before the next
// input is taken. A draw of a loaded glyph runs the dispatch and setup steps,
// 16 divider steps and an emit step for each vertex. The 16 steps come from the
// four-lane restoring divider that finds one quotient bit of every atlas
// coordinate per cycle. A draw of a missing glyph runs dispatch, setup and the
// miss step. Output stalls hold the sequencer on the current vertex. Reset
// clears the loaded flags at once, so no clearing pass is needed.
//
// The glyph table lives in a RAM read on the input transfer; a flag per entry
// marks entries that have been loaded, and only flagged entries are ever used.
`default_nettype none

`include "glyph_quad_vertex_generator_unit_assert.svh"

module glyph_quad_vertex_generator_unit #(
  parameter int GLYPH_ENTRIES = 256,
  parameter int PEN_BITS      = 23
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i,
  // Input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [7:0]          char_code_i,
  input  logic                start_of_text_i,
  input  logic [11:0]         glyph_x_i,
  input  logic [11:0]         glyph_y_i,
  input  logic [11:0]         glyph_w_i,
  input  logic [11:0]         glyph_h_i,
  input  logic signed [11:0]  bearing_x_i,
  input  logic signed [11:0]  bearing_y_i,
  input  logic [11:0]         pen_advance_i,
  // Result vertices
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [23:0]  pos_x_o,
  output logic signed [23:0]  pos_y_o,
  output logic [15:0]         tex_u_o,
  output logic [15:0]         tex_v_o,
  output logic                missing_glyph_o,
  output logic                last_o
);

  // Only codes below 256 can be presented, so the table never needs more rows.
  localparam int TBL_DEPTH = (GLYPH_ENTRIES < 256) ? GLYPH_ENTRIES : 256;
  localparam int IW        = $clog2(TBL_DEPTH);
  localparam int EW        = $bits(gqvg_pkg::glyph_t);
  // Horizontal positions: pen plus bearing plus width fit in PEN_BITS + 3.
  localparam int XW        = PEN_BITS + 3;
  localparam int CW        = (XW > 25) ? XW : 25;
  localparam logic signed [CW-1:0] POS_MAX = CW'(8388607);
  localparam logic signed [CW-1:0] POS_MIN = CW'(-8388608);

  function automatic logic [23:0] sat_pos(logic signed [XW-1:0] v);
    logic signed [CW-1:0] ext;
    logic [23:0]          res;
    ext = CW'(v);
    if (ext > POS_MAX) begin
      res = 24'h7FFFFF;
    end else if (ext < POS_MIN) begin
      res = 24'h800000;
    end else begin
      res = ext[23:0];
    end
    return res;
  endfunction

  // Sequencer
  gqvg_pkg::pc_e   pc_q, pc_d;
  gqvg_pkg::ctrl_t ctrl;
  logic            take_jmp;

  // Configuration registers
  logic [12:0] atlas_w_q, atlas_w_d;
  logic [12:0] atlas_h_q, atlas_h_d;

  // Latched input item
  logic             mode_q, mode_d;
  logic [7:0]       code_q, code_d;
  logic             sot_q, sot_d;
  gqvg_pkg::glyph_t ent_q, ent_d;

  // Glyph state
  logic [TBL_DEPTH-1:0] loaded_q, loaded_d;
  logic [PEN_BITS-1:0]  pen_q, pen_d;

  // Quad geometry
  logic [23:0] x0_q, x0_d, x1_q, x1_d;
  logic [15:0] yt_q, yt_d, yb_q, yb_d;

  // Divider lanes: u1, u2, v1, v2
  logic [12:0] rem_q [4];
  logic [12:0] rem_d [4];
  logic [15:0] quo_q [4];
  logic [15:0] quo_d [4];
  logic        sat_q [4];
  logic        sat_d [4];
  logic [3:0]  cnt_q, cnt_d;
  logic [12:0] lane_div [4];
  logic [12:0] lane_num [4];
  logic [13:0] lane_shl [4];
  logic        lane_ge  [4];
  logic [15:0] tex      [4];

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [23:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [15:0] out_u_q, out_u_d, out_v_q, out_v_d;
  logic        out_miss_q, out_miss_d;
  logic        out_last_q, out_last_d;
  logic        out_busy;

  // Table access
  logic             ram_we, ram_re;
  logic [EW-1:0]    ram_rdata;
  gqvg_pkg::glyph_t rd_ent;
  logic             in_acc;
  logic             code_ok;
  logic             miss;

  // Datapath helpers
  logic [PEN_BITS-1:0] pen_eff;
  logic signed [XW-1:0] x0_full, x1_full;
  logic [15:0]          yt_full;
  logic [PEN_BITS:0]    pen_sum;

  gqvg_ram #(
    .WIDTH (EW),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (code_q[IW-1:0]),
    .wdata_i (ent_q),
    .re_i    (ram_re),
    .raddr_i (char_code_i[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = gqvg_pkg::glyph_t'(ram_rdata);

  assign ctrl        = gqvg_pkg::ucode(pc_q);
  assign in_ready_o  = (ctrl.act == gqvg_pkg::ACT_ACCEPT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_busy    = out_valid_q && !out_ready_i;

  assign code_ok = ({24'd0, code_q} < 32'(GLYPH_ENTRIES));
  assign miss    = !(code_ok && loaded_q[code_q[IW-1:0]]);
  assign ram_re  = in_acc;
  assign ram_we  = (ctrl.act == gqvg_pkg::ACT_STORE) && code_ok;

  // Start of text zeroes the pen before the glyph is placed.
  assign pen_eff = sot_q ? '0 : pen_q;
  assign x0_full = $signed({3'b000, pen_eff}) + $signed({{(XW-12){rd_ent.bx[11]}}, rd_ent.bx});
  assign x1_full = x0_full + $signed({{(XW-12){1'b0}}, rd_ent.w});
  assign yt_full = {{4{rd_ent.by[11]}}, rd_ent.by} - {3'b000, atlas_h_q};
  assign pen_sum = {1'b0, pen_q} + {{(PEN_BITS-11){1'b0}}, rd_ent.adv};

  assign lane_div[0] = atlas_w_q;
  assign lane_div[1] = atlas_w_q;
  assign lane_div[2] = atlas_h_q;
  assign lane_div[3] = atlas_h_q;
  assign lane_num[0] = {1'b0, rd_ent.x};
  assign lane_num[1] = {1'b0, rd_ent.x} + {1'b0, rd_ent.w};
  assign lane_num[2] = {1'b0, rd_ent.y};
  assign lane_num[3] = {1'b0, rd_ent.y} + {1'b0, rd_ent.h};

  // One restoring step per lane; a numerator at or above the divisor (a zero
  // divisor included) saturates the coordinate.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_shl[i] = {rem_q[i], 1'b0};
      lane_ge[i]  = (lane_shl[i] >= {1'b0, lane_div[i]});
      tex[i]      = sat_q[i] ? gqvg_pkg::TEX_MAX : quo_q[i];
    end
  end

  always_comb begin
    case (ctrl.cond)
      gqvg_pkg::COND_ALWAYS:   take_jmp = 1'b1;
      gqvg_pkg::COND_NO_ACC:   take_jmp = !in_valid_i;
      gqvg_pkg::COND_DRAW:     take_jmp = mode_q;
      gqvg_pkg::COND_MISS:     take_jmp = miss;
      gqvg_pkg::COND_DIV_MORE: take_jmp = (cnt_q != 4'd0);
      gqvg_pkg::COND_OUT_BUSY: take_jmp = out_busy;
      default:                 take_jmp = 1'b1;
    endcase
    pc_d = take_jmp ? ctrl.jmp : ctrl.nxt;
  end

  always_comb begin
    atlas_w_d   = atlas_w_q;
    atlas_h_d   = atlas_h_q;
    mode_d      = mode_q;
    code_d      = code_q;
    sot_d       = sot_q;
    ent_d       = ent_q;
    loaded_d    = loaded_q;
    pen_d       = pen_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    yt_d        = yt_q;
    yb_d        = yb_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    sat_d       = sat_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_u_d     = out_u_q;
    out_v_d     = out_v_q;
    out_miss_d  = out_miss_q;
    out_last_d  = out_last_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == gqvg_pkg::REG_ATLAS_W) begin
        atlas_w_d = cfg_data_i;
      end else if (cfg_index_i == gqvg_pkg::REG_ATLAS_H) begin
        atlas_h_d = cfg_data_i;
      end
    end

    case (ctrl.act)
      gqvg_pkg::ACT_ACCEPT: begin
        if (in_acc) begin
          mode_d = mode_i;
          code_d = char_code_i;
          sot_d  = start_of_text_i;
          ent_d  = '{glyph_x_i, glyph_y_i, glyph_w_i, glyph_h_i,
                     bearing_x_i, bearing_y_i, pen_advance_i};
        end
      end
      gqvg_pkg::ACT_STORE: begin
        if (code_ok) begin
          loaded_d[code_q[IW-1:0]] = 1'b1;
        end
      end
      gqvg_pkg::ACT_SETUP: begin
        pen_d = pen_eff;
        x0_d  = sat_pos(x0_full);
        x1_d  = sat_pos(x1_full);
        yt_d  = yt_full;
        yb_d  = yt_full - {4'b0000, rd_ent.h};
        cnt_d = gqvg_pkg::DIV_LAST;
        for (int i = 0; i < 4; i++) begin
          sat_d[i] = (lane_num[i] >= lane_div[i]);
          rem_d[i] = lane_num[i];
          quo_d[i] = '0;
        end
      end
      gqvg_pkg::ACT_DIV: begin
        cnt_d = cnt_q - 4'd1;
        for (int i = 0; i < 4; i++) begin
          rem_d[i] = lane_ge[i] ? 13'(lane_shl[i] - {1'b0, lane_div[i]})
                                : lane_shl[i][12:0];
          quo_d[i] = {quo_q[i][14:0], lane_ge[i]};
        end
      end
      gqvg_pkg::ACT_EMIT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_x_d     = ctrl.right ? x1_q : x0_q;
          out_y_d     = ctrl.top ? {{8{yt_q[15]}}, yt_q} : {{8{yb_q[15]}}, yb_q};
          out_u_d     = ctrl.right ? tex[1] : tex[0];
          out_v_d     = ctrl.top ? tex[2] : tex[3];
          out_miss_d  = 1'b0;
          out_last_d  = ctrl.last;
          // The pen moves on with the final vertex, saturating.
          if (ctrl.last) begin
            pen_d = pen_sum[PEN_BITS] ? '1 : pen_sum[PEN_BITS-1:0];
          end
        end
      end
      gqvg_pkg::ACT_MISS: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_x_d     = '0;
          out_y_d     = '0;
          out_u_d     = '0;
          out_v_d     = '0;
          out_miss_d  = 1'b1;
          out_last_d  = ctrl.last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= gqvg_pkg::PC_WAIT;
      atlas_w_q   <= gqvg_pkg::ATLAS_RESET;
      atlas_h_q   <= gqvg_pkg::ATLAS_RESET;
      loaded_q    <= '0;
      pen_q       <= '0;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      atlas_w_q   <= atlas_w_d;
      atlas_h_q   <= atlas_h_d;
      loaded_q    <= loaded_d;
      pen_q       <= pen_d;
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    sot_q      <= sot_d;
    ent_q      <= ent_d;
    x0_q       <= x0_d;
    x1_q       <= x1_d;
    yt_q       <= yt_d;
    yb_q       <= yb_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    sat_q      <= sat_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_u_q    <= out_u_d;
    out_v_q    <= out_v_d;
    out_miss_q <= out_miss_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = out_x_q;
  assign pos_y_o         = out_y_q;
  assign tex_u_o         = out_u_q;
  assign tex_v_o         = out_v_q;
  assign missing_glyph_o = out_miss_q;
  assign last_o          = out_last_q;

  // An input transfer always leads to the dispatch step.
  `GQVG_ASSERT(a_accept_dispatch, in_acc |=> pc_q == gqvg_pkg::PC_DISPATCH)
  // A missing-glyph result is a single, all-zero, final result.
  `GQVG_ASSERT(a_miss_result, out_valid_o && missing_glyph_o |-> last_o && tex_u_o == 16'd0 && pos_x_o == 24'sd0)
  // The table is never written while it is being read.
  `GQVG_NEVER(a_ram_rw, ram_we && ram_re)

endmodule

`default_nettype wire
